@@ hw/rtl/range_min_max_segment_tree_macros.svh @@
// assertion helpers for range_min_max_segment_tree.sv
`ifndef RANGE_MIN_MAX_SEGMENT_TREE_MACROS_SVH
`define RANGE_MIN_MAX_SEGMENT_TREE_MACROS_SVH

// same-cycle implication, checked on clk and disabled in reset
`define RMM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk and disabled in reset
`define RMM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rmm_pkg.sv @@
package rmm_pkg;

  localparam int DATA_W     = 32;
  localparam int LEAF_IDX_W = 10;
  localparam int RANGE_W    = 11;
  localparam int CFG_IDX_W  = 1;

  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [LEAF_IDX_W-1:0]    leaf_idx_t;
  typedef logic [RANGE_W-1:0]       range_idx_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // combine modes
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  // register indexes
  localparam cfg_idx_t REG_COMBINE_MODE = 1'b0;
  localparam cfg_idx_t REG_IDENTITY     = 1'b1;

  localparam value_t IDENTITY_RESET = 32'sh8000_0000;

  // max or min of two signed values; equal values are bit-identical
  function automatic value_t combine_fn(logic mode, value_t a, value_t b);
    value_t y;
    if (mode == MODE_MIN) begin
      y = (b < a) ? b : a;
    end else begin
      y = (a < b) ? b : a;
    end
    return y;
  endfunction

endpackage

@@ hw/rtl/rmm_if.sv @@
interface rmm_req_if;
  import rmm_pkg::*;

  logic       valid;
  logic       ready;
  logic       operation;
  leaf_idx_t  leaf_index;
  value_t     new_value;
  range_idx_t range_start;
  range_idx_t range_end;

  modport source (
    output valid, operation, leaf_index, new_value, range_start, range_end,
    input  ready
  );
  modport sink (
    input  valid, operation, leaf_index, new_value, range_start, range_end,
    output ready
  );
endinterface

interface rmm_rsp_if;
  import rmm_pkg::*;

  logic   valid;
  logic   ready;
  value_t range_result;

  modport source (output valid, range_result, input ready);
  modport sink (input valid, range_result, output ready);
endinterface

@@ hw/rtl/range_min_max_segment_tree.sv @@
// range min/max segment tree: a bottom-up tree of 2*LEAVES signed 32-bit nodes in one
// memory with a write port and a registered read port, node 1 the root and the leaves at
// LEAVES..2*LEAVES-1. After reset a clearing pass writes the reset identity into every node,
// during which req.ready stays low (config writes are taken as usual).
// An update writes its leaf in the cycle it is accepted and then recombines one ancestor
// per cycle; an update to a leaf past the tree is dropped and gives no word.
// A query walks the covering nodes level by level with one memory read per covering node
// and the one shared combine unit, and waits if need be for the output register to be free;
// it returns one word. The result sits in an output register, so the next item is taken
// while a result waits to be collected.
// combine_mode (index 0) picks maximum or minimum, identity_value (index 1) is the value of
// an empty range; change them only while the block is idle. Stored inner nodes are not
// recomputed on a mode change.
`include "range_min_max_segment_tree_macros.svh"

module range_min_max_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  rmm_req_if.sink           req,
  rmm_rsp_if.source         rsp,
  input  logic              cfg_we,
  input  rmm_pkg::cfg_idx_t cfg_index,
  input  rmm_pkg::value_t   cfg_data
);
  import rmm_pkg::*;

  // widths follow the leaf count
  localparam int LW  = $clog2(LEAVES);
  localparam int AW  = LW + 1;                     // node address
  localparam int QW  = AW + 1;                     // query bound, holds 2*LEAVES
  localparam int CW  = (QW > RANGE_W) ? QW : RANGE_W;
  localparam int IW  = (LW + 1 > LEAF_IDX_W) ? LW + 1 : LEAF_IDX_W;

  localparam logic [QW-1:0] LEAVES_Q = QW'(LEAVES);
  localparam logic [QW-1:0] TWO_L    = QW'(2 * LEAVES);
  localparam logic [AW-1:0] ROOT     = AW'(1);
  localparam logic [AW-1:0] LAST_N   = AW'(2 * LEAVES - 1);

  // sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_QLVL = 3'd3;
  localparam logic [2:0] ST_QLD  = 3'd4;
  localparam logic [2:0] ST_QRD  = 3'd5;
  localparam logic [2:0] ST_QFIN = 3'd6;

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic [AW-1:0] pos, pos_next;          // node just written by an update
  value_t        acc, acc_next;          // value of that node
  value_t        accl, accl_next;        // left accumulator of a query
  value_t        accr, accr_next;        // right accumulator of a query
  logic [QW-1:0] lo, lo_next;
  logic [QW-1:0] hi, hi_next;

  logic          combine_mode;
  value_t        identity_value;

  logic          out_valid, out_valid_next;
  value_t        out_data, out_data_next;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  value_t        mem_rdata;

  // shared combine unit
  value_t        cmb_a, cmb_b, cmb_y;

  // input decode
  logic          accept;
  logic [IW-1:0] leaf_ext;
  logic          leaf_ok;
  logic [AW-1:0] leaf_addr;
  logic [CW-1:0] start_ext, end_ext;
  logic [QW-1:0] start_sat, end_sat;
  logic [AW-1:0] parent;
  logic [QW-1:0] hi_dec;
  logic [QW-1:0] lo_inc;
  logic          slot_free;

  // sequencer status
  logic          in_query;
  logic          result_load;

  rmm_node_mem #(
    .ADDR_W (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready        = (state == ST_IDLE);
  assign accept           = req.valid && req.ready;
  assign rsp.valid        = out_valid;
  assign rsp.range_result = out_data;
  assign slot_free        = !out_valid || rsp.ready;

  assign in_query    = (state == ST_QLVL) || (state == ST_QLD) || (state == ST_QRD) ||
                       (state == ST_QFIN);
  assign result_load = (state == ST_QFIN) && slot_free;

  // leaf decode, drop leaves past the tree
  assign leaf_ext  = IW'(req.leaf_index);
  assign leaf_ok   = leaf_ext < IW'(LEAVES);
  assign leaf_addr = {1'b1, leaf_ext[LW-1:0]};

  // saturate query bounds to the leaf count
  assign start_ext = CW'(req.range_start);
  assign end_ext   = CW'(req.range_end);
  assign start_sat = (start_ext > CW'(LEAVES)) ? LEAVES_Q : QW'(start_ext);
  assign end_sat   = (end_ext > CW'(LEAVES)) ? LEAVES_Q : QW'(end_ext);

  assign parent = {1'b0, pos[AW-1:1]};
  assign hi_dec = hi - QW'(1);
  assign lo_inc = lo + QW'(1);

  // operand select for the one combine unit
  always_comb begin
    unique case (state)
      ST_UPD: begin
        cmb_a = acc;
        cmb_b = mem_rdata;
      end
      ST_QLD: begin
        cmb_a = accl;
        cmb_b = mem_rdata;
      end
      ST_QRD: begin
        cmb_a = mem_rdata;
        cmb_b = accr;
      end
      default: begin
        cmb_a = accl;
        cmb_b = accr;
      end
    endcase
  end

  assign cmb_y = combine_fn(combine_mode, cmb_a, cmb_b);

  // sequencer
  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    pos_next       = pos;
    acc_next       = acc;
    accl_next      = accl;
    accr_next      = accr;
    lo_next        = lo;
    hi_next        = hi;
    out_valid_next = out_valid && !rsp.ready;
    out_data_next  = out_data;
    mem_we         = 1'b0;
    mem_waddr      = clr_cnt;
    mem_wdata      = IDENTITY_RESET;
    mem_raddr      = lo[AW-1:0];

    unique case (state)
      ST_CLR: begin
        mem_we       = 1'b1;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == LAST_N) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        mem_raddr = leaf_addr ^ AW'(1);
        if (accept) begin
          if (req.operation == OP_UPDATE) begin
            if (leaf_ok) begin
              // write the leaf, fetch its sibling at the same time
              mem_we     = 1'b1;
              mem_waddr  = leaf_addr;
              mem_wdata  = req.new_value;
              pos_next   = leaf_addr;
              acc_next   = req.new_value;
              state_next = ST_UPD;
            end
          end else begin
            accl_next = identity_value;
            accr_next = identity_value;
            lo_next   = start_sat + LEAVES_Q;
            hi_next   = end_sat + LEAVES_Q;
            if (start_sat < end_sat) begin
              state_next = ST_QLVL;
            end else begin
              state_next = ST_QFIN;
            end
          end
        end
      end

      ST_UPD: begin
        // one ancestor per cycle, sibling of the next one is read meanwhile
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = cmb_y;
        mem_raddr = parent ^ AW'(1);
        acc_next  = cmb_y;
        pos_next  = parent;
        if (parent == ROOT) begin
          state_next = ST_IDLE;
        end
      end

      ST_QLVL: begin
        if (lo >= hi) begin
          state_next = ST_QFIN;
        end else if (lo[0]) begin
          mem_raddr  = lo[AW-1:0];
          state_next = ST_QLD;
        end else if (hi[0]) begin
          mem_raddr  = hi_dec[AW-1:0];
          state_next = ST_QRD;
        end else begin
          lo_next = lo >> 1;
          hi_next = hi >> 1;
        end
      end

      ST_QLD: begin
        accl_next = cmb_y;
        mem_raddr = hi_dec[AW-1:0];
        if (hi[0]) begin
          lo_next    = lo_inc;
          state_next = ST_QRD;
        end else begin
          lo_next    = lo_inc >> 1;
          hi_next    = hi >> 1;
          state_next = ST_QLVL;
        end
      end

      ST_QRD: begin
        accr_next  = cmb_y;
        lo_next    = lo >> 1;
        hi_next    = hi_dec >> 1;
        state_next = ST_QLVL;
      end

      ST_QFIN: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_data_next  = cmb_y;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      out_valid <= out_valid_next;
    end
    pos      <= pos_next;
    acc      <= acc_next;
    accl     <= accl_next;
    accr     <= accr_next;
    lo       <= lo_next;
    hi       <= hi_next;
    out_data <= out_data_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode   <= MODE_MAX;
      identity_value <= IDENTITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMBINE_MODE: combine_mode   <= cfg_data[0];
        REG_IDENTITY:     identity_value <= cfg_data;
        default:          ;
      endcase
    end
  end

  `RMM_ASSERT_IMP(a_no_write_in_query, in_query, !mem_we, "node written during a query")
  `RMM_ASSERT_IMP(a_upd_not_node0, (state == ST_UPD), (mem_waddr != '0), "unused node written")
  `RMM_ASSERT_IMP(a_query_bound, (state == ST_QLVL), (hi <= TWO_L), "query bound past the tree")
  `RMM_ASSERT_NXT(a_result_loaded, result_load, (out_valid && req.ready), "result not loaded")

endmodule

@@ hw/rtl/rmm_node_mem.sv @@
module rmm_node_mem #(
  parameter int ADDR_W = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  rmm_pkg::value_t      wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output rmm_pkg::value_t      rdata
);
  import rmm_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ bench/tb_range_min_max_segment_tree.sv @@
`timescale 1ns / 1ps

module tb_range_min_max_segment_tree;
  import rmm_pkg::*;

  localparam int LEAVES      = 1024;
  localparam int NODES       = 2 * LEAVES;
  // long enough for an update tail, so this covers any tail of work
  localparam int SETTLE      = 48;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 335;
  localparam int CYCLE_LIMIT = 5000000;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  // one request word as the sender sees it
  typedef struct {
    logic       operation;
    leaf_idx_t  leaf_index;
    value_t     new_value;
    range_idx_t range_start;
    range_idx_t range_end;
  } tree_op_t;

  // shadow tree plus the queue of query answers still owed by the block
  class segment_tree_scoreboard;
    logic   mode;
    value_t ident;
    value_t nodes[NODES];
    value_t answers_q[$];
    int     errors;
    int     checked;
    int     updates;
    int     queries;

    function new();
      mode    = MODE_MAX;
      ident   = IDENTITY_RESET;
      errors  = 0;
      checked = 0;
      updates = 0;
      queries = 0;
      foreach (nodes[i]) nodes[i] = IDENTITY_RESET;
    endfunction

    function void set_register(cfg_idx_t idx, value_t data);
      if (idx == REG_COMBINE_MODE) begin
        mode = data[0];
      end else begin
        ident = data;
      end
    endfunction

    function value_t merge(value_t a, value_t b);
      if (mode == MODE_MIN) begin
        return (a <= b) ? a : b;
      end
      return (a >= b) ? a : b;
    endfunction

    function int outstanding();
      return answers_q.size();
    endfunction

    // called for every word the block accepts
    function void note_input(tree_op_t w);
      int     pos;
      int     lo;
      int     hi;
      value_t acc_lo;
      value_t acc_hi;
      if (w.operation == OP_UPDATE) begin
        updates++;
        if (int'(w.leaf_index) >= LEAVES) return;
        pos = LEAVES + int'(w.leaf_index);
        nodes[pos] = w.new_value;
        for (pos = pos >> 1; pos != 0; pos = pos >> 1) begin
          nodes[pos] = merge(nodes[2 * pos], nodes[2 * pos + 1]);
        end
      end else begin
        queries++;
        lo     = (int'(w.range_start) > LEAVES) ? LEAVES : int'(w.range_start);
        hi     = (int'(w.range_end) > LEAVES) ? LEAVES : int'(w.range_end);
        acc_lo = ident;
        acc_hi = ident;
        if (lo < hi) begin
          lo += LEAVES;
          hi += LEAVES;
          while (lo < hi) begin
            if (lo[0]) begin
              acc_lo = merge(acc_lo, nodes[lo]);
              lo++;
            end
            if (hi[0]) begin
              hi--;
              acc_hi = merge(nodes[hi], acc_hi);
            end
            lo = lo >> 1;
            hi = hi >> 1;
          end
        end
        answers_q = {answers_q, merge(acc_lo, acc_hi)};
      end
    endfunction

    // called for every word the block hands out
    function void check_result(value_t got);
      value_t want;
      if (answers_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %0d, no query pending", got);
        return;
      end
      want = answers_q.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("range_result mismatch at result %0d: expected %0d got %0d",
                   checked, want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  value_t cfg_data;

  rmm_req_if req_ch ();
  rmm_rsp_if rsp_ch ();

  segment_tree_scoreboard sb;
  bit rsp_calm;
  int cycle_count;
  int settings_done;

  range_min_max_segment_tree #(.LEAVES(LEAVES)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog, also covers the clearing pass after reset
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // result side: ready with random stalls, mostly short, a few long
  initial begin
    int stall;
    int r;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_calm) begin
        rsp_ch.ready = 1'b1;
        stall = 0;
      end else if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else begin
        rsp_ch.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 20) begin
          stall = $urandom_range(1, 3);
        end else if (r < 23) begin
          stall = $urandom_range(15, 60);
        end
      end
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.range_result);
  end

  // offer one word and hold it until the block takes it
  task automatic send_word(input tree_op_t w);
    @(negedge clk);
    req_ch.valid       = 1'b1;
    req_ch.operation   = w.operation;
    req_ch.leaf_index  = w.leaf_index;
    req_ch.new_value   = w.new_value;
    req_ch.range_start = w.range_start;
    req_ch.range_end   = w.range_end;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    sb.note_input(w);
  endtask

  task automatic idle_req(input int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
  endtask

  // stop sending until every query answer is back, then let an update tail finish
  task automatic drain_results();
    idle_req(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input value_t data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(input logic mode, input value_t ident);
    write_reg(REG_COMBINE_MODE, {{(DATA_W-1){1'b0}}, mode});
    write_reg(REG_IDENTITY, ident);
    settings_done++;
  endtask

  // don't-care fields of each word carry random noise
  function automatic tree_op_t make_update(int leaf, value_t val);
    tree_op_t w;
    w.operation   = OP_UPDATE;
    w.leaf_index  = leaf_idx_t'(leaf);
    w.new_value   = val;
    w.range_start = range_idx_t'($urandom);
    w.range_end   = range_idx_t'($urandom);
    return w;
  endfunction

  function automatic tree_op_t make_query(int lo, int hi);
    tree_op_t w;
    w.operation   = OP_QUERY;
    w.leaf_index  = leaf_idx_t'($urandom);
    w.new_value   = $urandom;
    w.range_start = range_idx_t'(lo);
    w.range_end   = range_idx_t'(hi);
    return w;
  endfunction

  // random word around a hot window so queries often see freshly written leaves
  function automatic tree_op_t random_word(int hot_base);
    tree_op_t w;
    int r;
    int lo;
    int hi;
    int leaf;
    value_t val;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      leaf = (hot_base + $urandom_range(0, 63)) % LEAVES;
    end else begin
      leaf = $urandom_range(0, LEAVES - 1);
    end
    case ($urandom_range(0, 19))
      0: begin
        val = VAL_MIN;
      end
      1: begin
        val = VAL_MAX;
      end
      2: begin
        val = '0;
      end
      3: begin
        val = -1;
      end
      default: begin
        val = $urandom;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // raw 11-bit bounds, often past the last leaf
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end else if (r < 30) begin
      lo = $urandom_range(0, LEAVES - 1);
      hi = $urandom_range(lo, LEAVES);
    end else if (r < 80) begin
      lo = hot_base + $urandom_range(0, 63);
      hi = lo + $urandom_range(0, 16);
    end else if (r < 90) begin
      lo = $urandom_range(0, 3);
      hi = $urandom_range(LEAVES - 4, LEAVES);
    end else begin
      // reversed or empty
      hi = $urandom_range(0, LEAVES - 1);
      lo = hi + $urandom_range(0, 40);
    end
    if ($urandom_range(0, 99) < 45) begin
      w = make_update(leaf, val);
    end else begin
      w = make_query(lo, hi);
      w.leaf_index = leaf_idx_t'(leaf);
      w.new_value  = val;
    end
    return w;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    logic   set_mode[PHASES];
    value_t set_ident[PHASES];
    bit     calm;
    int     hot_base;
    int     gap;

    sb                 = new();
    rsp_calm           = 1'b0;
    settings_done      = 0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_COMBINE_MODE;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_UPDATE;
    req_ch.leaf_index  = '0;
    req_ch.new_value   = '0;
    req_ch.range_start = '0;
    req_ch.range_end   = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // block is clearing after reset; the clearing pass holds off the first word by itself
    apply_setting(MODE_MAX, IDENTITY_RESET);

    // directed: fresh tree, extreme leaves and values, empty, reversed and saturated bounds
    send_word(make_query(0, LEAVES));
    send_word(make_update(0, VAL_MAX));
    send_word(make_update(LEAVES - 1, VAL_MIN));
    send_word(make_update(LEAVES / 2, '0));
    send_word(make_update(1, -1));
    send_word(make_update(LEAVES - 2, 32'sh7fff_fffe));
    send_word(make_query(0, LEAVES));
    send_word(make_query(0, 1));
    send_word(make_query(LEAVES - 1, LEAVES));
    send_word(make_query(1, LEAVES - 1));
    send_word(make_query(5, 5));
    send_word(make_query(700, 3));
    send_word(make_query(0, 2047));
    send_word(make_query(2047, 2047));
    send_word(make_query(LEAVES, LEAVES));
    send_word(make_query(2047, 0));
    send_word(make_query(LEAVES / 2 - 1, LEAVES / 2 + 1));
    send_word(make_query(LEAVES, 2047));

    // mode flip over a filled tree: inner nodes keep their max-mode values
    drain_results();
    apply_setting(MODE_MIN, VAL_MAX);
    send_word(make_query(0, LEAVES));
    send_word(make_query(1, LEAVES - 1));
    send_word(make_query(LEAVES / 2, LEAVES / 2 + 1));
    send_word(make_update(LEAVES / 2, VAL_MIN));
    send_word(make_query(0, LEAVES));
    send_word(make_query(3, 3));

    // random phases over extreme and random register settings
    set_mode[0] = MODE_MIN; set_ident[0] = VAL_MAX;
    set_mode[1] = MODE_MAX; set_ident[1] = VAL_MIN;
    set_mode[2] = MODE_MAX; set_ident[2] = '0;
    set_mode[3] = MODE_MIN; set_ident[3] = VAL_MIN;
    set_mode[4] = MODE_MAX; set_ident[4] = $urandom;
    set_mode[5] = MODE_MIN; set_ident[5] = $urandom;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      apply_setting(set_mode[p], set_ident[p]);
      // one phase runs with no idling on either side
      calm     = (p == 2);
      rsp_calm = calm;
      hot_base = $urandom_range(0, LEAVES - 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word(hot_base));
        if ($urandom_range(0, 199) == 0) begin
          drain_results();
        end else begin
          gap = pick_gap(calm);
          if (gap > 0) idle_req(gap);
        end
        if ($urandom_range(0, 63) == 0) hot_base = $urandom_range(0, LEAVES - 1);
      end
    end
    rsp_calm = 1'b0;

    // wait for the last answers, then a quiet tail to catch stray words
    idle_req(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d updates and %0d queries over %0d register settings",
             sb.updates, sb.queries, settings_done);
    $display("%0d results checked, %0d errors, %0d answers still owed",
             sb.checked, sb.errors, sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
